/* sv/sbr_pkg.sv */
// ----------------------------------------------------------------------------
// sbr_pkg: shared types and constants of the stream byte reassembler
// Field widths of the segment and delivery beats, and the sequencer states.
// ----------------------------------------------------------------------------
package sbr_pkg;

    localparam int IDX_W  = 64;
    localparam int BYTE_W = 8;
    localparam int ROOM_W = 7;
    localparam int PEND_W = 7;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EVAL   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_FINISH = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_FETCH  = 6'b100000
    } sbr_state_t;

endpackage

/* sv/sbr_if.sv */
// ----------------------------------------------------------------------------
// sbr_if: segment and delivery channels of the stream byte reassembler
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sbr_segment_if;
    import sbr_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  stream_index;
    logic              byte_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              ends_final_segment;
    logic [ROOM_W-1:0] room;

    modport source (output valid, stream_index, byte_valid, data_byte,
                    ends_final_segment, room, input ready);
    modport sink   (input valid, stream_index, byte_valid, data_byte,
                    ends_final_segment, room, output ready);
endinterface

interface sbr_delivery_if;
    import sbr_pkg::*;

    logic              valid;
    logic              ready;
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              stream_closed;
    logic              run_last;
    logic [PEND_W-1:0] pending_bytes;

    modport source (output valid, out_valid, out_byte, stream_closed, run_last,
                    pending_bytes, input ready);
    modport sink   (input valid, out_valid, out_byte, stream_closed, run_last,
                    pending_bytes, output ready);
endinterface

/* sv/sbr_window_store.sv */
// ----------------------------------------------------------------------------
// sbr_window_store: byte memory of the reassembly window
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sbr_window_store #(
    parameter int WINDOW = 64
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(WINDOW)-1:0]  wr_addr,
    input  logic [sbr_pkg::BYTE_W-1:0] wr_data,
    input  logic [$clog2(WINDOW)-1:0]  rd_addr,
    output logic [sbr_pkg::BYTE_W-1:0] rd_data
);
    import sbr_pkg::*;

    logic [BYTE_W-1:0] mem_array [WINDOW];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/stream_byte_reassembler_core.sv */
// ----------------------------------------------------------------------------
// stream_byte_reassembler_core: in-order byte reassembly of a segmented stream
// Holds out-of-order bytes in a window store and delivers contiguous runs.
// ----------------------------------------------------------------------------
// Each segment beat carries one byte (or an empty end marker) with its absolute
// stream index. A byte is accepted into a window of room bytes (saturated at
// WINDOW) starting at the next expected index; bytes before it or beyond the
// window are dropped, bytes ahead of it are held once in the window store.
// When the expected byte arrives it is delivered, followed by every held byte
// that continues it. Every segment beat yields at least one delivery beat:
// either the delivered bytes, the last one flagged with run_last, or a single
// beat with out_valid low. All beats of one step report the closed flag and
// the pending count as they stand at the end of that step. A segment that
// delivers nothing goes from acceptance through evaluation and finish to its
// delivery beat. The cost per byte comes from the scan of held marks (one slot
// per cycle, to learn the run length before the first beat goes out) and from
// the registered read of the window store during the drain. Only one segment
// is in work at a time. No clearing pass is needed after reset: the held marks
// sit in flip-flops and the store is read only at marked slots.
// ----------------------------------------------------------------------------
module stream_byte_reassembler_core #(
    parameter int WINDOW = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    sbr_segment_if.sink    segment,
    sbr_delivery_if.source delivery
);
    import sbr_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SLOT_W + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [ROOM_W-1:0] ROOM_MAX  = ROOM_W'(WINDOW);

    // sequencer and stream state
    sbr_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   ne_reg, ne_next;
    logic [SLOT_W-1:0]  ne_slot_reg, ne_slot_next;
    logic               final_known_reg, final_known_next;
    logic [IDX_W-1:0]   final_end_reg, final_end_next;
    logic               closed_reg, closed_next;
    logic [CNT_W-1:0]   held_cnt_reg, held_cnt_next;
    logic [WINDOW-1:0]  marks_reg, marks_next;
    logic [SLOT_W-1:0]  run_cnt_reg, run_cnt_next;
    logic [SLOT_W-1:0]  rd_slot_reg, rd_slot_next;
    logic               emit_reg, emit_next;
    logic               first_reg, first_next;

    // captured segment beat
    logic [IDX_W-1:0]   in_idx_reg;
    logic               in_has_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_fin_reg;
    logic [ROOM_W-1:0]  in_room_reg;

    // classification of the captured beat
    logic [ROOM_W-1:0]  room_sat;
    logic [IDX_W-1:0]   offset;
    logic               idx_ahead;
    logic               beyond;
    logic               in_order;
    logic               do_hold;
    logic [SUM_W-1:0]   hold_sum;
    logic [SLOT_W-1:0]  hold_slot;
    logic               store_en;
    logic [IDX_W-1:0]   fin_end;
    logic [BYTE_W-1:0]  rd_data;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    assign room_sat  = (in_room_reg > ROOM_MAX) ? ROOM_MAX : in_room_reg;
    assign idx_ahead = in_idx_reg >= ne_reg;
    assign offset    = in_idx_reg - ne_reg;
    assign beyond    = in_has_reg && idx_ahead && (offset >= IDX_W'(room_sat));
    // with no room at all even the expected byte lies beyond the window
    assign in_order  = in_has_reg && idx_ahead && !beyond && (offset == '0);
    assign do_hold   = in_has_reg && idx_ahead && !beyond && (offset != '0);
    // offset is below WINDOW when held, so one compare-subtract wraps the slot
    assign hold_sum  = SUM_W'(ne_slot_reg) + offset[SUM_W-1:0];
    assign hold_slot = (hold_sum >= SUM_W'(WINDOW)) ?
                       SLOT_W'(hold_sum - SUM_W'(WINDOW)) : hold_sum[SLOT_W-1:0];
    assign fin_end   = in_idx_reg + IDX_W'(in_has_reg);
    assign store_en  = (state_reg == ST_EVAL) && !closed_reg && do_hold &&
                       !marks_reg[hold_slot];

    sbr_window_store #(
        .WINDOW (WINDOW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (hold_slot),
        .wr_data (in_byte_reg),
        .rd_addr (rd_slot_reg),
        .rd_data (rd_data)
    );

    // Capture the segment beat; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (segment.valid && segment.ready)
        begin
            in_idx_reg  <= segment.stream_index;
            in_has_reg  <= segment.byte_valid;
            in_byte_reg <= segment.data_byte;
            in_fin_reg  <= segment.ends_final_segment;
            in_room_reg <= segment.room;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        ne_next          = ne_reg;
        ne_slot_next     = ne_slot_reg;
        final_known_next = final_known_reg;
        final_end_next   = final_end_reg;
        closed_next      = closed_reg;
        held_cnt_next    = held_cnt_reg;
        marks_next       = marks_reg;
        run_cnt_next     = run_cnt_reg;
        rd_slot_next     = rd_slot_reg;
        emit_next        = emit_reg;
        first_next       = first_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (segment.valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                run_cnt_next = '0;
                first_next   = 1'b1;
                emit_next    = 1'b0;
                if (!closed_reg)
                begin
                    // hold an ahead-of-order byte once; a duplicate keeps the first
                    if (store_en)
                    begin
                        marks_next[hold_slot] = 1'b1;
                        held_cnt_next         = held_cnt_reg + 1'b1;
                    end
                    if (in_fin_reg && !beyond)
                    begin
                        final_known_next = 1'b1;
                        final_end_next   = fin_end;
                    end
                    if (in_order)
                    begin
                        ne_next      = ne_reg + 1'b1;
                        ne_slot_next = slot_inc(ne_slot_reg);
                        rd_slot_next = slot_inc(ne_slot_reg);
                        emit_next    = 1'b1;
                    end
                end
                state_next = (in_order && !closed_reg) ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                // advance over the held run one slot per cycle
                if (marks_reg[ne_slot_reg] && (run_cnt_reg != LAST_SLOT))
                begin
                    marks_next[ne_slot_reg] = 1'b0;
                    if (held_cnt_reg != '0)
                    begin
                        held_cnt_next = held_cnt_reg - 1'b1;
                    end
                    ne_next      = ne_reg + 1'b1;
                    ne_slot_next = slot_inc(ne_slot_reg);
                    run_cnt_next = run_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                closed_next = closed_reg || (final_known_reg && (final_end_reg <= ne_reg));
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (delivery.ready)
                begin
                    if (!emit_reg || (run_cnt_reg == '0))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (!first_reg)
                        begin
                            rd_slot_next = slot_inc(rd_slot_reg);
                        end
                        first_next = 1'b0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                // wait out the store read, consume one held byte
                run_cnt_next = run_cnt_reg - 1'b1;
                state_next   = ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ne_reg          <= '0;
            ne_slot_reg     <= '0;
            final_known_reg <= 1'b0;
            final_end_reg   <= '0;
            closed_reg      <= 1'b0;
            held_cnt_reg    <= '0;
            marks_reg       <= '0;
            run_cnt_reg     <= '0;
            rd_slot_reg     <= '0;
            emit_reg        <= 1'b0;
            first_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ne_reg          <= ne_next;
            ne_slot_reg     <= ne_slot_next;
            final_known_reg <= final_known_next;
            final_end_reg   <= final_end_next;
            closed_reg      <= closed_next;
            held_cnt_reg    <= held_cnt_next;
            marks_reg       <= marks_next;
            run_cnt_reg     <= run_cnt_next;
            rd_slot_reg     <= rd_slot_next;
            emit_reg        <= emit_next;
            first_reg       <= first_next;
        end
    end

    assign segment.ready           = (state_reg == ST_IDLE);
    assign delivery.valid          = (state_reg == ST_EMIT);
    assign delivery.out_valid      = emit_reg;
    assign delivery.out_byte       = !emit_reg ? '0 : (first_reg ? in_byte_reg : rd_data);
    assign delivery.stream_closed  = closed_reg;
    assign delivery.run_last       = !emit_reg || (run_cnt_reg == '0);
    assign delivery.pending_bytes  = PEND_W'(held_cnt_reg);

    // pending count tracks the held marks exactly
    a_count_matches_marks: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg == CNT_W'($countones(marks_reg)))
        else $error("pending count differs from number of held marks");

    // once closed, the stream stays closed
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("stream reopened after close");

    // between steps, the next expected slot is never marked as held
    a_expected_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !marks_reg[ne_slot_reg])
        else $error("next expected slot is marked held");

    // a delivery beat is never offered while a new segment can be taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        delivery.valid |-> !segment.ready)
        else $error("segment accepted while a delivery beat is pending");

    // the store is written only when no drain is in progress
    a_write_outside_drain: assert property (@(posedge clk) disable iff (!rst_n)
        store_en |-> ((state_reg == ST_EVAL) && (run_cnt_reg == '0) || (state_reg == ST_EVAL)))
        else $error("window store written outside evaluation");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the stream byte reassembler core
// Feeds bytes in and out of order with random sender and receiver idling.
// A scoreboard predicts every delivery beat and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import sbr_pkg::*;

    localparam int WIN         = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 32;
    localparam int MAX_REPORTS = 25;

    typedef struct packed {
        logic [IDX_W-1:0]  stream_index;
        logic              byte_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              ends_final_segment;
        logic [ROOM_W-1:0] room;
    } segment_beat_t;

    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              stream_closed;
        logic              run_last;
        logic [PEND_W-1:0] pending_bytes;
    } delivery_beat_t;

    // Kinds of off-stream beats mixed into the well-formed runs.
    typedef enum int {
        NZ_FAR_BYTE,
        NZ_STALE_BYTE,
        NZ_FAR_END,
        NZ_EMPTY
    } noise_kind_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own copy of the reassembly state, turns every
    // accepted segment beat into the delivery beats it must cause, and
    // checks delivery beats against them in order.
    // ------------------------------------------------------------------------
    class delivery_scoreboard;
        logic [BYTE_W-1:0] held_byte [WIN];
        bit                held_mark [WIN];
        bit [IDX_W-1:0]    next_idx;
        bit                end_known;
        bit [IDX_W-1:0]    end_idx;
        bit                closed;
        int unsigned       held_total;
        delivery_beat_t    due_beats [$];
        int                errors;
        int                segments;
        int                dropped;
        int                beats_checked;
        int                bytes_delivered;
        int                cur_run;
        int                longest_run;

        task report(input string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        function void note_segment(input segment_beat_t s);
            logic [BYTE_W-1:0] run_bytes [$];
            delivery_beat_t    b;
            bit [IDX_W-1:0]    off;
            int                win;
            int                slot;
            bit                beyond;
            segments++;
            win    = (s.room > WIN) ? WIN : int'(s.room);
            beyond = 1'b0;
            if (!closed)
            begin
                if (s.byte_valid && s.stream_index >= next_idx)
                begin
                    off = s.stream_index - next_idx;
                    if (off >= win)
                    begin
                        beyond = 1'b1;
                        dropped++;
                    end
                    else if (off == 0)
                    begin
                        // Deliver the expected byte, then the held run behind it.
                        run_bytes.push_back(s.data_byte);
                        next_idx++;
                        slot = int'(next_idx % WIN);
                        while (run_bytes.size() < WIN && held_mark[slot])
                        begin
                            run_bytes.push_back(held_byte[slot]);
                            held_mark[slot] = 1'b0;
                            if (held_total > 0)
                                held_total--;
                            next_idx++;
                            slot = int'(next_idx % WIN);
                        end
                    end
                    else
                    begin
                        // Keep the first copy of a held byte.
                        slot = int'(s.stream_index % WIN);
                        if (!held_mark[slot])
                        begin
                            held_mark[slot] = 1'b1;
                            held_byte[slot] = s.data_byte;
                            held_total++;
                        end
                    end
                end
                else if (s.byte_valid)
                begin
                    dropped++;
                end
                if (s.ends_final_segment && !beyond)
                begin
                    end_known = 1'b1;
                    end_idx   = s.stream_index + s.byte_valid;
                end
                if (end_known && end_idx <= next_idx)
                    closed = 1'b1;
            end
            b.stream_closed = closed;
            b.pending_bytes = PEND_W'(held_total);
            if (run_bytes.size() == 0)
            begin
                b.out_valid = 1'b0;
                b.out_byte  = '0;
                b.run_last  = 1'b1;
                due_beats.push_back(b);
            end
            else
            begin
                foreach (run_bytes[k])
                begin
                    b.out_valid = 1'b1;
                    b.out_byte  = run_bytes[k];
                    b.run_last  = (k == run_bytes.size() - 1);
                    due_beats.push_back(b);
                end
            end
        endfunction

        task check_delivery(input delivery_beat_t got);
            delivery_beat_t want;
            if (due_beats.size() == 0)
            begin
                report($sformatf("delivery beat with nothing due (byte %02h)", got.out_byte));
                return;
            end
            // Take the oldest due beat off the head of the queue.
            want = due_beats[0];
            due_beats.delete(0);
            beats_checked++;
            if (got.out_valid !== want.out_valid)
                report($sformatf("beat %0d out_valid %b, want %b",
                                 beats_checked, got.out_valid, want.out_valid));
            if (got.out_byte !== want.out_byte)
                report($sformatf("beat %0d out_byte %02h, want %02h",
                                 beats_checked, got.out_byte, want.out_byte));
            if (got.stream_closed !== want.stream_closed)
                report($sformatf("beat %0d stream_closed %b, want %b",
                                 beats_checked, got.stream_closed, want.stream_closed));
            if (got.run_last !== want.run_last)
                report($sformatf("beat %0d run_last %b, want %b",
                                 beats_checked, got.run_last, want.run_last));
            if (got.pending_bytes !== want.pending_bytes)
                report($sformatf("beat %0d pending_bytes %0d, want %0d",
                                 beats_checked, got.pending_bytes, want.pending_bytes));
            if (want.out_valid)
            begin
                bytes_delivered++;
                cur_run++;
                if (want.run_last)
                begin
                    if (cur_run > longest_run)
                        longest_run = cur_run;
                    cur_run = 0;
                end
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    sbr_segment_if  seg_ch ();
    sbr_delivery_if dlv_ch ();

    stream_byte_reassembler_core #(
        .WINDOW (WIN)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .segment  (seg_ch.sink),
        .delivery (dlv_ch.source)
    );

    delivery_scoreboard sb = new();

    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int rcv_hold_left = 0;
    int useful        = 0;
    int quiet_cycles  = 0;

    delivery_beat_t seen_beat;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: drop ready at random, or hold it low for a counted stretch
    // when the stimulus asks for back-pressure.
    // ------------------------------------------------------------------------
    initial
    begin
        dlv_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rcv_hold_left > 0)
            begin
                rcv_hold_left--;
                dlv_ch.ready <= 1'b0;
            end
            else
            begin
                dlv_ch.ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
            end
        end
    end

    // Check every delivery beat at the edge that moves it.
    always @(posedge clk)
    begin
        if (rst_n && dlv_ch.valid && dlv_ch.ready)
        begin
            seen_beat.out_valid     = dlv_ch.out_valid;
            seen_beat.out_byte      = dlv_ch.out_byte;
            seen_beat.stream_closed = dlv_ch.stream_closed;
            seen_beat.run_last      = dlv_ch.run_last;
            seen_beat.pending_bytes = dlv_ch.pending_bytes;
            sb.check_delivery(seen_beat);
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (seg_ch.valid && seg_ch.ready) || (dlv_ch.valid && dlv_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles, %0d beats still due",
                         quiet_cycles, sb.due_beats.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: idle at random, present one segment beat at the falling edge,
    // hold it until the block takes it, then note it in the scoreboard.
    // ------------------------------------------------------------------------
    task automatic send_segment(input logic [IDX_W-1:0] idx, input logic bv,
                                input logic [BYTE_W-1:0] data, input logic fin,
                                input logic [ROOM_W-1:0] room);
        segment_beat_t s;
        s.stream_index       = idx;
        s.byte_valid         = bv;
        s.data_byte          = data;
        s.ends_final_segment = fin;
        s.room               = room;
        while ($urandom_range(99, 0) < snd_idle_pct)
        begin
            @(negedge clk);
            seg_ch.valid <= 1'b0;
        end
        @(negedge clk);
        seg_ch.valid              <= 1'b1;
        seg_ch.stream_index       <= idx;
        seg_ch.byte_valid         <= bv;
        seg_ch.data_byte          <= data;
        seg_ch.ends_final_segment <= fin;
        seg_ch.room               <= room;
        @(posedge clk);
        while (!seg_ch.ready)
            @(posedge clk);
        sb.note_segment(s);
    endtask

    // Pick a room that mostly keeps the byte inside the window.
    function automatic logic [ROOM_W-1:0] pick_room(input bit [IDX_W-1:0] idx);
        bit [IDX_W-1:0] off;
        int             pick;
        off  = idx - sb.next_idx;
        pick = $urandom_range(99, 0);
        if (idx < sb.next_idx || off >= WIN || pick >= 92)
            return ROOM_W'($urandom_range(127, 0));
        if (pick < 50)
            return ROOM_W'(WIN);
        if (pick < 70)
            return ROOM_W'($urandom_range(127, WIN + 1));
        return ROOM_W'($urandom_range(WIN, int'(off) + 1));
    endfunction

    function automatic int run_len();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 75)
            return $urandom_range(8, 1);
        if (pick < 95)
            return $urandom_range(24, 9);
        return $urandom_range(48, 25);
    endfunction

    // Off-stream beats: far bytes, stale bytes, far end markers, empty beats.
    // None of them may close the stream.
    task automatic send_noise();
        bit [IDX_W-1:0] idx;
        bit             bv;
        bit             fin;
        noise_kind_t    kind;
        kind = noise_kind_t'($urandom_range(3, 0));
        idx  = {$urandom, $urandom};
        bv   = 1'b0;
        fin  = 1'b0;
        if (kind == NZ_STALE_BYTE && sb.next_idx == 0)
            kind = NZ_EMPTY;
        case (kind)
            NZ_FAR_BYTE:
            begin
                idx[IDX_W-1] = 1'b1;
                bv           = $urandom_range(1, 0);
                fin          = $urandom_range(1, 0);
            end
            NZ_STALE_BYTE:
            begin
                idx = sb.next_idx - $urandom_range(
                          (sb.next_idx < 40) ? int'(sb.next_idx) : 40, 1);
                bv  = 1'b1;
            end
            NZ_FAR_END:
            begin
                idx = sb.next_idx + 1000 + $urandom_range(1 << 20, 0);
                fin = 1'b1;
            end
            default:
            begin
                bv  = 1'b0;
            end
        endcase
        send_segment(idx, bv, BYTE_W'($urandom), fin, ROOM_W'($urandom_range(127, 0)));
    endtask

    // Send one run of the stream from the next expected index in shuffled
    // order. A tight run fills the whole window before the first byte lands.
    task automatic send_run(input int len, input bit tight);
        int             order [$];
        int             k;
        int             j;
        int             tmp;
        bit [IDX_W-1:0] base;
        bit [IDX_W-1:0] idx;
        base = sb.next_idx;
        for (k = 0; k < len; k++)
            order.push_back(k);
        for (k = len - 1; k > 0; k--)
        begin
            j        = $urandom_range(k, 0);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        if (tight || $urandom_range(1, 0) == 1)
        begin
            j = 0;
            for (k = 0; k < len; k++)
            begin
                if (order[k] == 0)
                    j = k;
            end
            order.delete(j);
            order.push_back(0);
        end
        for (k = 0; k < len; k++)
        begin
            idx = base + order[k];
            send_segment(idx, 1'b1, BYTE_W'($urandom), 1'b0,
                         tight ? ROOM_W'(WIN) : pick_room(idx));
            useful++;
            if (!tight && $urandom_range(99, 0) < 12)
            begin
                idx = base + order[$urandom_range(k, 0)];
                send_segment(idx, 1'b1, BYTE_W'($urandom), 1'b0, pick_room(idx));
                useful++;
            end
            if (!tight && $urandom_range(99, 0) < 10)
                send_noise();
        end
    endtask

    // Withdraw the last beat, then wait until every due beat has come back.
    task automatic wait_drained();
        @(negedge clk);
        seg_ch.valid <= 1'b0;
        while (sb.due_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct, input int target,
                             input bit with_full, input int hold);
        int goal;
        snd_idle_pct  = snd_pct;
        rcv_idle_pct  = rcv_pct;
        goal          = useful + target;
        rcv_hold_left = hold;
        if (with_full)
            send_run(WIN, 1'b1);
        while (useful < goal)
            send_run(run_len(), 1'b0);
        // Pause the sender until every due beat has come back.
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        bit [IDX_W-1:0] base;
        rst_n                     = 1'b0;
        seg_ch.valid              = 1'b0;
        seg_ch.stream_index       = '0;
        seg_ch.byte_valid         = 1'b0;
        seg_ch.data_byte          = '0;
        seg_ch.ends_final_segment = 1'b0;
        seg_ch.room               = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        snd_idle_pct = 24;
        rcv_idle_pct = 66;

        // Directed: window edges, room extremes, duplicates, end markers.
        send_segment(64'd0,  1'b1, 8'h00, 1'b0, 7'd64);   // expected byte
        send_segment(64'd0,  1'b1, 8'hFF, 1'b0, 7'd127);  // stale, room saturates
        send_segment(64'd65, 1'b1, 8'h11, 1'b0, 7'd127);  // one past window end
        send_segment(64'd64, 1'b1, 8'hFF, 1'b0, 7'd127);  // last slot of window
        send_segment(64'd1,  1'b1, 8'h22, 1'b0, 7'd0);    // no room at all
        send_segment(64'd1,  1'b1, 8'h80, 1'b0, 7'd1);    // room of one
        send_segment(64'd3,  1'b1, 8'hA5, 1'b0, 7'd2);    // hold ahead
        send_segment(64'd3,  1'b1, 8'h5A, 1'b0, 7'd64);   // duplicate, first kept
        send_segment(64'd2,  1'b1, 8'h7F, 1'b0, 7'd64);   // deliver two
        send_segment(64'h1234_5678_9ABC_DEF0, 1'b0, 8'h00, 1'b0, 7'd64);
        // Empty end marker at the top index is recorded; a byte there with the
        // end flag lies beyond the window, so its wrapped end is not recorded.
        send_segment(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00, 1'b1, 7'd64);
        send_segment(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'hC3, 1'b1, 7'd127);
        send_segment(64'd74, 1'b1, 8'h3C, 1'b1, 7'd64);
        send_segment(64'h0000_0000_0010_0000, 1'b0, 8'h00, 1'b1, 7'h40);
        send_segment(64'h5555_5555_5555_5555, 1'b1, 8'h55, 1'b0, 7'h2A);
        send_segment(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 8'hAA, 1'b0, 7'h55);
        send_segment(64'd4,  1'b1, 8'h01, 1'b0, 7'd64);
        useful = 17;

        // Random runs: slow receiver with one long hold-off, then slow
        // sender, then both at full rate.
        run_phase(24, 66, 85, 1'b1, 250);
        run_phase(66, 24, 85, 1'b0, 0);
        run_phase(0,  0,  85, 1'b1, 0);

        // Close the stream with bytes still held past its end, then show
        // that later beats are ignored.
        base = sb.next_idx;
        send_segment(base + 5,  1'b1, BYTE_W'($urandom), 1'b0, 7'd64);
        send_segment(base + 10, 1'b1, BYTE_W'($urandom), 1'b0, 7'd64);
        send_segment(base + 3,  1'b1, BYTE_W'($urandom), 1'b1, 7'd64);
        send_segment(base + 1,  1'b1, BYTE_W'($urandom), 1'b0, 7'd64);
        send_segment(base + 2,  1'b1, BYTE_W'($urandom), 1'b0, 7'd64);
        send_segment(base,      1'b1, BYTE_W'($urandom), 1'b0, 7'd127);
        send_segment(base + 4,  1'b1, BYTE_W'($urandom), 1'b0, 7'd64);
        send_segment(base + 6,  1'b0, 8'h00, 1'b1, 7'd64);
        send_noise();
        send_noise();

        @(negedge clk);
        seg_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.due_beats.size() != 0)
            sb.report($sformatf("%0d delivery beats never arrived", sb.due_beats.size()));

        $display("run: %0d segment beats (%0d dropped), %0d delivery beats checked,",
                 sb.segments, sb.dropped, sb.beats_checked);
        $display("run: %0d bytes in order, longest run %0d, closed=%0b, %0d bytes left held",
                 sb.bytes_delivered, sb.longest_run, sb.closed, sb.held_total);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
